// ----- rtl/pfdm_pkg.sv -----
// pfdm_pkg: widths, reset values, codes and shared types of the pwm meter
// no dependencies; used by the interfaces and every module of the meter but the divider

package pfdm_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 16;

	localparam int unsigned PRE_W     = 16;
	localparam int unsigned BUS_W     = 28;
	localparam int unsigned TMO_W     = 16;
	localparam int unsigned ELAPSED_W = 16;
	localparam int unsigned FREQ_W    = 32;
	localparam int unsigned DUTY_W    = 10;
	localparam int unsigned SCALE_W   = 11;
	localparam int unsigned PERMIL_W  = 10;

	localparam int unsigned CFG_DATA_W = 28;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PERMIL_W-1:0]  PERMIL          = PERMIL_W'(1000);
	localparam logic [SCALE_W-1:0]   MILLI_TWICE     = SCALE_W'(2000);
	localparam logic [DUTY_W-1:0]    DUTY_MAX        = DUTY_W'(1000);
	localparam logic [FREQ_W-1:0]    FREQ_MAX        = '1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = '1;
	localparam logic [PRE_W-1:0]     PRESCALER_RESET = '0;
	localparam logic [BUS_W-1:0]     BUS_CLOCK_RESET = BUS_W'(36000000);
	localparam logic [TMO_W-1:0]     TIMEOUT_RESET   = TMO_W'(200);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESCALER = 2'd0,
		CFG_BUS_CLOCK = 2'd1,
		CFG_TIMEOUT   = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_CAPTURE = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	// classification of one queued word
	typedef struct packed {
		op_t  op;
		logic period_zero;
	} cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DUTY_START,
		ST_DUTY_WAIT,
		ST_FREQ_START,
		ST_FREQ_WAIT,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/pfdm_in_if.sv -----
// pfdm_in_if: input channel of the pwm meter, capture events and ticks
// depends on pfdm_pkg for the default count width

interface pfdm_in_if #(
	parameter int unsigned COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [COUNT_WIDTH-1:0] period_count;
	logic [COUNT_WIDTH-1:0] high_count;

	modport source (output valid, req_type, period_count, high_count, input ready);
	modport sink (input valid, req_type, period_count, high_count, output ready);
endinterface

// ----- rtl/pfdm_out_if.sv -----
// pfdm_out_if: result channel of the pwm meter, frequency, duty and presence
// depends on pfdm_pkg for the field widths

interface pfdm_out_if ();
	logic                          valid;
	logic                          ready;
	logic [pfdm_pkg::FREQ_W-1:0]   freq_millihertz;
	logic [pfdm_pkg::DUTY_W-1:0]   duty_permil;
	logic                          signal_present;

	modport source (output valid, freq_millihertz, duty_permil, signal_present, input ready);
	modport sink (input valid, freq_millihertz, duty_permil, signal_present, output ready);
endinterface

// ----- rtl/pfdm_front.sv -----
// pfdm_front: accepts input words, classifies them and holds them in a short queue
// depends on pfdm_pkg and pfdm_in_if

module pfdm_front #(
	parameter int unsigned COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pfdm_in_if.sink                in_stream,
	output logic                   head_valid,
	output pfdm_pkg::cls_t         head_cls,
	output logic [COUNT_WIDTH-1:0] head_period,
	output logic [COUNT_WIDTH-1:0] head_high,
	input  logic                   pop
);

	pfdm_pkg::cls_t                  cls_q    [pfdm_pkg::QUEUE_DEPTH];
	logic [COUNT_WIDTH-1:0]          period_q [pfdm_pkg::QUEUE_DEPTH];
	logic [COUNT_WIDTH-1:0]          high_q   [pfdm_pkg::QUEUE_DEPTH];
	logic [pfdm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [pfdm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [pfdm_pkg::QCNT_W-1:0]     cnt_q;
	logic                            push;
	pfdm_pkg::cls_t                  cls_in;

	assign in_stream.ready = (cnt_q != pfdm_pkg::QCNT_W'(pfdm_pkg::QUEUE_DEPTH));
	assign push            = in_stream.valid && in_stream.ready;

	always_comb begin
		cls_in.op          = pfdm_pkg::op_t'(in_stream.req_type);
		cls_in.period_zero = (in_stream.period_count == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cls_q[wr_ptr_q]    <= cls_in;
			period_q[wr_ptr_q] <= in_stream.period_count;
			high_q[wr_ptr_q]   <= in_stream.high_count;
		end
	end

	assign head_valid  = (cnt_q != '0);
	assign head_cls    = cls_q[rd_ptr_q];
	assign head_period = period_q[rd_ptr_q];
	assign head_high   = high_q[rd_ptr_q];

endmodule

// ----- rtl/pfdm_divider.sv -----
// pfdm_divider: restoring divider, one quotient bit per cycle
// depends on nothing but its parameters

module pfdm_divider #(
	parameter int unsigned NUM_W = 39,
	parameter int unsigned DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   cand;
	logic [DEN_W:0]   diff;
	logic             qbit;

	// shift in the next dividend bit and try to subtract
	always_comb begin
		cand = {rem_q, acc_q[NUM_W-1]};
		diff = cand - {1'b0, den_q};
		qbit = !diff[DEN_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			acc_q <= {acc_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = acc_q;

endmodule

// ----- rtl/pfdm_back.sv -----
// pfdm_back: sequencer that carries out queued words, keeps the readings and
// drives the result register; depends on pfdm_pkg, pfdm_out_if, pfdm_divider

module pfdm_back #(
	parameter int unsigned COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  pfdm_pkg::cls_t                    head_cls,
	input  logic [COUNT_WIDTH-1:0]            head_period,
	input  logic [COUNT_WIDTH-1:0]            head_high,
	output logic                              pop,
	input  logic [pfdm_pkg::PRE_W-1:0]        prescaler,
	input  logic [pfdm_pkg::BUS_W-1:0]        bus_clock_hz,
	input  logic [pfdm_pkg::TMO_W-1:0]        timeout_ms,
	pfdm_out_if.source                        out_stream
);

	localparam int unsigned DUTY_NUM_W = COUNT_WIDTH + pfdm_pkg::PERMIL_W;
	localparam int unsigned FREQ_NUM_W = pfdm_pkg::BUS_W + pfdm_pkg::SCALE_W;
	localparam int unsigned DEN_W      = COUNT_WIDTH + pfdm_pkg::PRE_W + 1;
	localparam int unsigned NUM_W      = (DUTY_NUM_W > FREQ_NUM_W) ? DUTY_NUM_W : FREQ_NUM_W;

	pfdm_pkg::state_t state_q, state_d;

	logic tick_upd, cap_zero, mul_en, div_start, div_sel_freq;
	logic duty_en, freq_en, load_out;

	logic [DUTY_NUM_W-1:0]          duty_num_q;
	logic [FREQ_NUM_W-1:0]          freq_num_q;
	logic [DEN_W-1:0]               freq_den_q;
	logic [pfdm_pkg::FREQ_W-1:0]    freq_q;
	logic [pfdm_pkg::DUTY_W-1:0]    duty_q;
	logic [pfdm_pkg::ELAPSED_W-1:0] elapsed_q;

	logic                           out_valid_q;
	logic [pfdm_pkg::FREQ_W-1:0]    out_freq_q;
	logic [pfdm_pkg::DUTY_W-1:0]    out_duty_q;
	logic                           out_present_q;

	logic [NUM_W-1:0]               div_num;
	logic [DEN_W-1:0]               div_den;
	logic                           div_busy;
	logic                           div_done;
	logic [NUM_W-1:0]               div_quot;
	logic [pfdm_pkg::DUTY_W-1:0]    duty_sat;
	logic [pfdm_pkg::FREQ_W-1:0]    freq_sat;
	logic                           present;
	logic                           slot_free;

	assign slot_free = !out_valid_q || out_stream.ready;
	assign present   = (elapsed_q < timeout_ms);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		tick_upd     = 1'b0;
		cap_zero     = 1'b0;
		mul_en       = 1'b0;
		div_start    = 1'b0;
		div_sel_freq = 1'b0;
		duty_en      = 1'b0;
		freq_en      = 1'b0;
		load_out     = 1'b0;
		pop          = 1'b0;
		unique case (state_q)
			pfdm_pkg::ST_IDLE: begin
				if (head_valid) begin
					if (head_cls.op == pfdm_pkg::OP_TICK) begin
						tick_upd = 1'b1;
						state_d  = pfdm_pkg::ST_DONE;
					end else if (head_cls.period_zero) begin
						cap_zero = 1'b1;
						state_d  = pfdm_pkg::ST_DONE;
					end else begin
						mul_en  = 1'b1;
						state_d = pfdm_pkg::ST_DUTY_START;
					end
				end
			end
			pfdm_pkg::ST_DUTY_START: begin
				div_start = 1'b1;
				state_d   = pfdm_pkg::ST_DUTY_WAIT;
			end
			pfdm_pkg::ST_DUTY_WAIT: begin
				if (div_done) begin
					duty_en = 1'b1;
					state_d = pfdm_pkg::ST_FREQ_START;
				end
			end
			pfdm_pkg::ST_FREQ_START: begin
				div_start    = 1'b1;
				div_sel_freq = 1'b1;
				state_d      = pfdm_pkg::ST_FREQ_WAIT;
			end
			pfdm_pkg::ST_FREQ_WAIT: begin
				if (div_done) begin
					freq_en = 1'b1;
					state_d = pfdm_pkg::ST_DONE;
				end
			end
			pfdm_pkg::ST_DONE: begin
				if (slot_free) begin
					load_out = 1'b1;
					pop      = 1'b1;
					state_d  = pfdm_pkg::ST_IDLE;
				end
			end
			default: state_d = pfdm_pkg::ST_IDLE;
		endcase
	end

	// operand products, one multiplier each
	always_ff @(posedge clk) begin
		if (mul_en) begin
			duty_num_q <= DUTY_NUM_W'(head_high) * DUTY_NUM_W'(pfdm_pkg::PERMIL);
			freq_num_q <= FREQ_NUM_W'(bus_clock_hz) * FREQ_NUM_W'(pfdm_pkg::MILLI_TWICE);
			freq_den_q <= DEN_W'(head_period) * (DEN_W'(prescaler) + DEN_W'(1));
		end
	end

	assign div_num = div_sel_freq ? NUM_W'(freq_num_q) : NUM_W'(duty_num_q);
	assign div_den = div_sel_freq ? freq_den_q : DEN_W'(head_period);

	pfdm_divider #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		if ((|div_quot[NUM_W-1:pfdm_pkg::DUTY_W]) ||
		    (div_quot[pfdm_pkg::DUTY_W-1:0] > pfdm_pkg::DUTY_MAX)) begin
			duty_sat = pfdm_pkg::DUTY_MAX;
		end else begin
			duty_sat = div_quot[pfdm_pkg::DUTY_W-1:0];
		end
		if (|div_quot[NUM_W-1:pfdm_pkg::FREQ_W]) begin
			freq_sat = pfdm_pkg::FREQ_MAX;
		end else begin
			freq_sat = div_quot[pfdm_pkg::FREQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q    <= '0;
			duty_q    <= '0;
			elapsed_q <= '0;
		end else begin
			if (tick_upd && (elapsed_q != pfdm_pkg::ELAPSED_MAX)) begin
				elapsed_q <= elapsed_q + 1'b1;
			end
			if (cap_zero) begin
				freq_q    <= '0;
				duty_q    <= '0;
				elapsed_q <= '0;
			end
			if (duty_en) begin
				duty_q <= duty_sat;
			end
			if (freq_en) begin
				freq_q    <= freq_sat;
				elapsed_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_freq_q    <= present ? freq_q : '0;
			out_duty_q    <= present ? duty_q : '0;
			out_present_q <= present;
		end
	end

	assign out_stream.valid           = out_valid_q;
	assign out_stream.freq_millihertz = out_freq_q;
	assign out_stream.duty_permil     = out_duty_q;
	assign out_stream.signal_present  = out_present_q;

`ifndef ASSERT_OFF
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		duty_q <= pfdm_pkg::DUTY_MAX)
		else $error("stored duty above full scale");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == pfdm_pkg::ST_DUTY_WAIT || state_q == pfdm_pkg::ST_FREQ_WAIT))
		else $error("divider result outside a wait state");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_present_q) |-> (out_freq_q == '0 && out_duty_q == '0))
		else $error("readings reported without signal");
`endif

endmodule

// ----- rtl/pwm_frequency_duty_meter.sv -----
// pwm_frequency_duty_meter: pwm frequency and duty meter, top level with config registers
// depends on pfdm_pkg, pfdm_in_if, pfdm_out_if, pfdm_front, pfdm_back
// a tick or a zero-period capture goes from the queue through the done state to the result register
// a capture with nonzero period first goes through the shared divider, which makes one
// quotient bit per cycle, duty then frequency
// one word is carried out at a time; a two-word queue keeps the input taking words meanwhile
// reset clears readings, elapsed time, queue and result valid flag; config takes reset values

module pwm_frequency_duty_meter #(
	parameter int unsigned COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	pfdm_in_if.sink                             in_stream,
	pfdm_out_if.source                          out_stream,
	input  logic                                cfg_we,
	input  logic [pfdm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfdm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [pfdm_pkg::PRE_W-1:0] prescaler_q;
	logic [pfdm_pkg::BUS_W-1:0] bus_clock_q;
	logic [pfdm_pkg::TMO_W-1:0] timeout_q;

	logic                   head_valid;
	pfdm_pkg::cls_t         head_cls;
	logic [COUNT_WIDTH-1:0] head_period;
	logic [COUNT_WIDTH-1:0] head_high;
	logic                   pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescaler_q <= pfdm_pkg::PRESCALER_RESET;
			bus_clock_q <= pfdm_pkg::BUS_CLOCK_RESET;
			timeout_q   <= pfdm_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (pfdm_pkg::cfg_idx_t'(cfg_index))
				pfdm_pkg::CFG_PRESCALER: prescaler_q <= cfg_data[pfdm_pkg::PRE_W-1:0];
				pfdm_pkg::CFG_BUS_CLOCK: bus_clock_q <= cfg_data[pfdm_pkg::BUS_W-1:0];
				pfdm_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data[pfdm_pkg::TMO_W-1:0];
				default: ;
			endcase
		end
	end

	pfdm_front #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_stream   (in_stream),
		.head_valid  (head_valid),
		.head_cls    (head_cls),
		.head_period (head_period),
		.head_high   (head_high),
		.pop         (pop)
	);

	pfdm_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cls     (head_cls),
		.head_period  (head_period),
		.head_high    (head_high),
		.pop          (pop),
		.prescaler    (prescaler_q),
		.bus_clock_hz (bus_clock_q),
		.timeout_ms   (timeout_q),
		.out_stream   (out_stream)
	);

endmodule

// ----- verif/pwm_frequency_duty_meter_check.sv -----
// pwm_frequency_duty_meter_check: predicts every result word of the pwm meter and compares
// depends on pfdm_pkg and the pfdm_in_if / pfdm_out_if channels; watches the config port too

module pwm_frequency_duty_meter_check
	import pfdm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	pfdm_in_if                    in_ch,
	pfdm_out_if                   out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fails,
	output int                    pending,
	output int                    checked
);

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DUTY_W-1:0] duty;
		logic              present;
	} reading_t;

	reading_t readings_due[$];

	logic [PRE_W-1:0]     prescaler_reg;
	logic [BUS_W-1:0]     bus_clock_reg;
	logic [TMO_W-1:0]     timeout_reg;
	logic [FREQ_W-1:0]    freq_held;
	logic [DUTY_W-1:0]    duty_held;
	logic [ELAPSED_W-1:0] elapsed;

	initial begin
		fails = 0;
		pending = 0;
		checked = 0;
	end

	// advance the meter by one word and give the reading it reports
	function automatic reading_t meter_step(input op_t op,
		input logic [COUNT_WIDTH_DEF-1:0] period, input logic [COUNT_WIDTH_DEF-1:0] high);
		logic [63:0] duty_q;
		logic [63:0] den;
		logic [63:0] freq_q;
		reading_t    r;
		if (op == OP_CAPTURE) begin
			if (period == '0) begin
				duty_held = '0;
				freq_held = '0;
			end else begin
				duty_q = (64'(high) * 64'(PERMIL)) / 64'(period);
				den = 64'(period) * (64'(prescaler_reg) + 64'd1);
				freq_q = (64'(MILLI_TWICE) * 64'(bus_clock_reg)) / den;
				if (duty_q > 64'(DUTY_MAX))
					duty_q = 64'(DUTY_MAX);
				if (freq_q > 64'(FREQ_MAX))
					freq_q = 64'(FREQ_MAX);
				duty_held = duty_q[DUTY_W-1:0];
				freq_held = freq_q[FREQ_W-1:0];
			end
			elapsed = '0;
		end else if (elapsed != ELAPSED_MAX) begin
			elapsed = elapsed + 1'b1;
		end
		r.present = (ELAPSED_W'(elapsed) < ELAPSED_W'(timeout_reg));
		r.freq = r.present ? freq_held : '0;
		r.duty = r.present ? duty_held : '0;
		return r;
	endfunction

	always @(posedge clk) begin
		reading_t want;
		if (!arst_n) begin
			prescaler_reg = PRESCALER_RESET;
			bus_clock_reg = BUS_CLOCK_RESET;
			timeout_reg = TIMEOUT_RESET;
			freq_held = '0;
			duty_held = '0;
			elapsed = '0;
			readings_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PRESCALER: prescaler_reg = cfg_data[PRE_W-1:0];
					CFG_BUS_CLOCK: bus_clock_reg = cfg_data[BUS_W-1:0];
					CFG_TIMEOUT:   timeout_reg = cfg_data[TMO_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				readings_due.push_back(meter_step(op_t'(in_ch.req_type),
					in_ch.period_count, in_ch.high_count));
			if (out_ch.valid && out_ch.ready) begin
				if (readings_due.size() == 0) begin
					fails++;
					$error("result word with no reading due: freq %0d duty %0d present %0b",
						out_ch.freq_millihertz, out_ch.duty_permil, out_ch.signal_present);
				end else begin
					want = readings_due.pop_front();
					checked++;
					if (out_ch.freq_millihertz !== want.freq) begin
						fails++;
						$error("freq_millihertz: expected %0d, actual %0d",
							want.freq, out_ch.freq_millihertz);
					end
					if (out_ch.duty_permil !== want.duty) begin
						fails++;
						$error("duty_permil: expected %0d, actual %0d",
							want.duty, out_ch.duty_permil);
					end
					if (out_ch.signal_present !== want.present) begin
						fails++;
						$error("signal_present: expected %0b, actual %0b",
							want.present, out_ch.signal_present);
					end
				end
			end
		end
		pending = readings_due.size();
	end

endmodule

// ----- verif/pwm_frequency_duty_meter_test.sv -----
// pwm_frequency_duty_meter_test: stimulus, receiver stalls, watchdog and verdict for the meter
// depends on pfdm_pkg, pfdm_in_if, pfdm_out_if, the meter rtl and pwm_frequency_duty_meter_check

module pwm_frequency_duty_meter_test;
	import pfdm_pkg::*;

	localparam int CW          = COUNT_WIDTH_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 90;

	typedef enum int {
		RX_FREE,
		RX_SPARSE,
		RX_RUNS
	} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fails;
	int                    pending;
	int                    checked;

	pfdm_in_if #(.COUNT_WIDTH(CW)) in_ch ();
	pfdm_out_if out_ch ();

	pwm_frequency_duty_meter #(.COUNT_WIDTH(CW)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_ch),
		.out_stream (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	pwm_frequency_duty_meter_check meter_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver side
	rx_mode_t rx_mode = RX_FREE;
	bit       hold_req = 1'b0;
	int       hold_left = 0;
	int       run_left = 0;
	logic     rx_level = 1'b1;

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE:   out_ch.ready <= 1'b1;
				RX_SPARSE: out_ch.ready <= ($urandom_range(0, 9) < 7);
				default: begin
					if (run_left == 0) begin
						rx_level = ~rx_level;
						run_left = $urandom_range(1, 8);
					end
					run_left--;
					out_ch.ready <= rx_level;
				end
			endcase
		end
	end

	// nothing accepted for too long means the block is stuck
	int quiet = 0;

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// sender side
	int burst_left = 0;
	int gap_max = 0;
	int tick_pct = 50;
	int cur_timeout = TIMEOUT_RESET;
	int n_capt = 0;
	int n_tick = 0;
	int n_settings = 1;

	task automatic idle_in(input int n);
		repeat (n) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			in_ch.req_type <= op_t'($urandom_range(0, 1));
			in_ch.period_count <= CW'($urandom);
			in_ch.high_count <= CW'($urandom);
		end
	endtask

	task automatic send_word(input op_t op, input logic [CW-1:0] period,
		input logic [CW-1:0] high);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max > 0)
				idle_in($urandom_range(1, gap_max));
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.req_type <= op;
		in_ch.period_count <= period;
		in_ch.high_count <= high;
		if (op == OP_CAPTURE)
			n_capt++;
		else
			n_tick++;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// stop offering words and let every due reading come out
	task automatic drain();
		idle_in(1);
		while (pending != 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input logic [PRE_W-1:0] pre, input logic [BUS_W-1:0] bus,
		input logic [TMO_W-1:0] tmo);
		drain();
		write_reg(CFG_PRESCALER, CFG_DATA_W'(pre));
		write_reg(CFG_BUS_CLOCK, CFG_DATA_W'(bus));
		write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		cur_timeout = tmo;
		n_settings++;
	endtask

	task automatic set_regs_random();
		logic [PRE_W-1:0] pre;
		logic [BUS_W-1:0] bus;
		logic [TMO_W-1:0] tmo;
		case ($urandom_range(0, 3))
			0:       pre = '0;
			1:       pre = '1;
			2:       pre = PRE_W'($urandom_range(1, 15));
			default: pre = PRE_W'($urandom);
		endcase
		case ($urandom_range(0, 6))
			0:       bus = '0;
			1:       bus = BUS_W'(1);
			2:       bus = BUS_W'(200000000);
			3:       bus = '1;
			4:       bus = BUS_CLOCK_RESET;
			default: bus = BUS_W'($urandom_range(1, 200000000));
		endcase
		case ($urandom_range(0, 6))
			0:       tmo = '0;
			1:       tmo = TMO_W'(1);
			2:       tmo = '1;
			3:       tmo = TIMEOUT_RESET;
			default: tmo = TMO_W'($urandom_range(2, 12));
		endcase
		set_regs(pre, bus, tmo);
	endtask

	function automatic logic [CW-1:0] pick_period();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return '0;
		else if (pick < 6)
			return CW'($urandom_range(1, 16));
		else if (pick == 6)
			return '1;
		return CW'($urandom);
	endfunction

	function automatic logic [CW-1:0] pick_high(input logic [CW-1:0] period);
		case ($urandom_range(0, 3))
			0:       return CW'($urandom);
			1:       return CW'($urandom_range(0, period));
			2:       return period;
			default: return period + CW'($urandom_range(1, 50));
		endcase
	endfunction

	// one random word, or a capture followed by up to 16 ticks, or by ticks to just past a short timeout
	task automatic send_random(output int sent);
		logic [CW-1:0] period;
		int            run;
		period = pick_period();
		sent = 1;
		if ($urandom_range(0, 99) < tick_pct) begin
			send_word(OP_TICK, CW'($urandom), CW'($urandom));
		end else if ($urandom_range(0, 9) == 0) begin
			send_word(OP_CAPTURE, period, pick_high(period));
			run = (cur_timeout > 16) ? $urandom_range(1, 16) : cur_timeout + $urandom_range(0, 2);
			repeat (run)
				send_word(OP_TICK, CW'($urandom), CW'($urandom));
			sent += run;
		end else begin
			send_word(OP_CAPTURE, period, pick_high(period));
		end
	endtask

	initial begin
		int sent;
		int n;
		in_ch.valid = 1'b0;
		in_ch.req_type = OP_CAPTURE;
		in_ch.period_count = '0;
		in_ch.high_count = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PRESCALER;
		cfg_data = '0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset registers first, then the extreme settings
		send_word(OP_CAPTURE, '0, '0);
		send_word(OP_CAPTURE, CW'(1), '0);
		send_word(OP_CAPTURE, '1, '1);
		send_word(OP_CAPTURE, CW'(1000), CW'(2000));
		send_word(OP_CAPTURE, CW'(36000), CW'(18000));
		send_word(OP_TICK, '1, '1);
		send_word(OP_TICK, '0, '0);
		send_word(OP_CAPTURE, '0, '1);
		send_word(OP_CAPTURE, CW'(16'h8000), CW'(16'h7fff));
		set_regs('1, '1, TMO_W'(1));
		send_word(OP_CAPTURE, CW'(1), CW'(1));
		send_word(OP_TICK, '1, '0);
		send_word(OP_TICK, '0, '1);
		send_word(OP_CAPTURE, CW'(16'h5555), CW'(16'h2aaa));
		// zero timeout and zero bus clock
		set_regs('0, '0, '0);
		send_word(OP_CAPTURE, CW'(100), CW'(50));
		send_word(OP_TICK, '0, '0);
		set_regs('0, BUS_W'(200000000), TMO_W'(3));
		send_word(OP_CAPTURE, CW'(1), CW'(1));
		repeat (3)
			send_word(OP_TICK, CW'($urandom), CW'($urandom));
		send_word(OP_CAPTURE, CW'(2), CW'(1));

		for (int phase = 0; phase < PHASES; phase++) begin
			set_regs_random();
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			case ($urandom_range(0, 2))
				0:       gap_max = 0;
				1:       gap_max = 3;
				default: gap_max = 12;
			endcase
			tick_pct = $urandom_range(20, 80);
			if (phase == 2)
				gap_max = 0;
			n = 0;
			while (n < PHASE_WORDS) begin
				if (phase == 2 && n >= 10 && n < 12)
					hold_req = 1'b1;
				if (phase == 5 && n >= 45 && n < 47)
					drain();
				send_random(sent);
				n += sent;
			end
		end

		// full-scale timeout keeps the readings present across a run of ticks
		set_regs('0, BUS_CLOCK_RESET, '1);
		rx_mode = RX_FREE;
		gap_max = 0;
		send_word(OP_CAPTURE, CW'(500), CW'(250));
		repeat (12)
			send_word(OP_TICK, CW'($urandom), CW'($urandom));

		drain();
		repeat (10)
			@(negedge clk);
		$display("covered %0d captures and %0d ticks under %0d register settings",
			n_capt, n_tick, n_settings);
		$display("%0d result words compared, with random stalls and one %0d-cycle hold-off",
			checked, LONG_HOLD);
		if (fails == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/pfdm_pkg.sv
rtl/pfdm_in_if.sv
rtl/pfdm_out_if.sv
rtl/pfdm_front.sv
rtl/pfdm_divider.sv
rtl/pfdm_back.sv
rtl/pwm_frequency_duty_meter.sv
verif/pwm_frequency_duty_meter_check.sv
verif/pwm_frequency_duty_meter_test.sv
